// ----- rtl/core/poly1305_mac_core_assert.svh -----
// assertion macros used by the core back end
`ifndef POLY1305_MAC_CORE_ASSERT_SVH
`define POLY1305_MAC_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge out of reset
`define P1305_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("p1305 assertion failed");
// antecedent in one cycle implies consequent in the next
`define P1305_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("p1305 assertion failed");
`else
`define P1305_ASSERT(lbl, prop)
`define P1305_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/p1305_pkg.sv -----
package p1305_pkg;

	// key clamping masks for r
	localparam logic [63:0] CLAMP_LO = 64'h0FFF_FFFC_0FFF_FFFF;
	localparam logic [63:0] CLAMP_HI = 64'h0FFF_FFFC_0FFF_FFFC;

	// configuration register indexes
	localparam logic [2:0] REG_R_LOW  = 3'd0;
	localparam logic [2:0] REG_R_HIGH = 3'd1;
	localparam logic [2:0] REG_S_LOW  = 3'd2;
	localparam logic [2:0] REG_S_HIGH = 3'd3;

	// multiply passes, one 16-bit digit of the 132-bit sum each
	localparam int unsigned MUL_PASSES = 9;

	typedef struct packed {
		logic [63:0] block_low;
		logic [63:0] block_high;
		logic [4:0]  byte_count;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [63:0] tag_low;
		logic [63:0] tag_high;
	} out_item_t;

	// padded block as it sits in the queue
	typedef struct packed {
		logic [128:0] m;
		logic         last;
	} blk_t;

endpackage

// ----- rtl/core/poly1305_mac_core.sv -----
// Poly1305 authenticator core. Write the 32-byte key through the config channel
// (index 0/1 = r low/high, clamped internally; 2/3 = s low/high) while idle, then
// push message blocks of 1 to 16 bytes; mark the final block with last to get the
// 16-byte tag, after which the accumulator starts fresh. In the back end each block
// is first added to the accumulator, then makes nine passes of a 16-by-124-bit
// multiply that walks the sum one 16-bit digit at a time, reducing modulo 2^130-5
// as it goes; a final block then gets a full reduction step and the s addition.
// A two-entry queue lets the next blocks be pushed meanwhile.
module poly1305_mac_core import p1305_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] r_low_q;
	logic [63:0] r_high_q;
	logic [63:0] s_low_q;
	logic [63:0] s_high_q;
	logic        q_valid;
	logic        q_pop;
	blk_t        q_data;

	assign cfg_ready = 1'b1;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_low_q <= '0;
			r_high_q <= '0;
			s_low_q <= '0;
			s_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_R_LOW:  r_low_q <= cfg_data;
				REG_R_HIGH: r_high_q <= cfg_data;
				REG_S_LOW:  s_low_q <= cfg_data;
				REG_S_HIGH: s_high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	p1305_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	p1305_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.r_key   ({r_high_q & CLAMP_HI, r_low_q & CLAMP_LO}),
		.s_key   ({s_high_q, s_low_q}),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ----- rtl/core/p1305_front.sv -----
module p1305_front import p1305_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	output logic     q_valid,
	output blk_t     q_data,
	input  logic     q_pop
);

	logic [4:0]   n_sat;
	logic [128:0] pad_bit;
	logic [128:0] keep_mask;
	blk_t         blk_in;
	blk_t         mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         wr_en;

	// saturate the byte count, mask unused bytes and place the pad bit
	always_comb begin
		n_sat = (item.byte_count > 5'd16) ? 5'd16 : item.byte_count;
		pad_bit = 129'd1 << {n_sat, 3'b000};
		keep_mask = pad_bit - 129'd1;
		blk_in.m = ({1'b0, item.block_high, item.block_low} & keep_mask) | pad_bit;
		blk_in.last = item.last;
	end

	assign full = (count_q == 2'd2);
	assign wr_en = push && !full;
	assign q_valid = (count_q != 2'd0);
	assign q_data = mem_q[rd_ptr_q];

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= blk_in;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (q_pop && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/core/p1305_back.sv -----
`include "poly1305_mac_core_assert.svh"
module p1305_back import p1305_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  blk_t         q_data,
	output logic         q_pop,
	input  logic [127:0] r_key,
	input  logic [127:0] s_key,
	output logic         empty,
	input  logic         pop,
	output out_item_t    result
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_RED  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t       state_q;
	logic [130:0] acc_q;
	logic [143:0] h_q;
	logic [130:0] p_q;
	logic [3:0]   cnt_q;
	logic         last_q;
	logic         out_valid_q;
	out_item_t    result_q;

	logic [15:0]  digit;
	logic [143:0] prod;
	logic [147:0] x_sum;
	logic [130:0] p_next;
	logic [130:0] p_fold;
	logic [130:0] g_sum;
	logic [127:0] h_fin;
	logic [127:0] tag;
	logic         fin_fire;

	// horner step: shift by one digit, add digit times r, fold above 2^130
	always_comb begin
		digit = h_q[{cnt_q, 4'b0000} +: 16];
		prod = 144'(digit) * 144'(r_key);
		x_sum = {1'b0, p_q, 16'b0} + {4'b0, prod};
		p_next = {1'b0, x_sum[129:0]} + 131'(21'(x_sum[147:130]) * 21'd5);
	end

	// final reduction and addition of s
	always_comb begin
		p_fold = {1'b0, p_q[129:0]} + (p_q[130] ? 131'd5 : 131'd0);
		g_sum = p_q + 131'd5;
		h_fin = g_sum[130] ? g_sum[127:0] : p_q[127:0];
		tag = h_fin + s_key;
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign fin_fire = (state_q == S_FIN) && (!out_valid_q || pop);
	assign empty = !out_valid_q;
	assign result = result_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (cnt_q == 4'd0) begin
						if (last_q) begin
							state_q <= S_RED;
						end else begin
							acc_q <= p_next;
							state_q <= S_IDLE;
						end
					end
				end
				S_RED: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_fire) begin
						acc_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			h_q <= 144'(acc_q) + 144'(q_data.m);
			last_q <= q_data.last;
			p_q <= '0;
			cnt_q <= 4'(MUL_PASSES - 1);
		end
		if (state_q == S_MUL) begin
			p_q <= p_next;
			cnt_q <= cnt_q - 4'd1;
		end
		if (state_q == S_RED) begin
			p_q <= p_fold;
		end
		if (fin_fire) begin
			result_q.tag_low <= tag[63:0];
			result_q.tag_high <= tag[127:64];
		end
	end

	`P1305_ASSERT_NEXT(a_start_mul, q_pop, state_q == S_MUL)
	`P1305_ASSERT_NEXT(a_mid_block_idle, state_q == S_MUL && cnt_q == 4'd0 && !last_q, state_q == S_IDLE)
	`P1305_ASSERT_NEXT(a_tag_clears_acc, fin_fire, acc_q == '0 && out_valid_q)

endmodule
